FILE: sv/oftl_pkg.sv
// ----------------------------------------------------------------------------
// oftl_pkg
// shared types and constants for the openflow 1.0 flow table lookup core
// ----------------------------------------------------------------------------
package oftl_pkg;

   localparam int DEFAULT_TABLE_DEPTH = 64;

   localparam logic [1:0] CMD_LOOKUP = 2'd0;
   localparam logic [1:0] CMD_APPEND = 2'd1;
   localparam logic [1:0] CMD_REMOVE = 2'd2;
   localparam logic [1:0] CMD_CLEAR  = 2'd3;

   localparam logic [1:0] ST_OK   = 2'd0;
   localparam logic [1:0] ST_FULL = 2'd1;
   localparam logic [1:0] ST_SLOT = 2'd2;

   localparam logic [15:0] ETH_IPV4 = 16'h0800;
   localparam logic [15:0] ETH_ARP  = 16'h0806;
   localparam logic [7:0]  PROTO_ICMP = 8'd1;
   localparam logic [7:0]  PROTO_TCP  = 8'd6;
   localparam logic [7:0]  PROTO_UDP  = 8'd17;

   localparam int WC_PORT = 0;
   localparam int WC_DLSRC = 2;
   localparam int WC_DLDST = 3;
   localparam int WC_DLTYPE = 4;
   localparam int WC_PROTO = 5;
   localparam int WC_TPSRC = 6;
   localparam int WC_TPDST = 7;

   // one table entry, also the packet header on lookup
   typedef struct packed {
      logic [31:0] wildcards;
      logic [15:0] in_port;
      logic [47:0] eth_src;
      logic [47:0] eth_dst;
      logic [15:0] ethertype;
      logic [31:0] ip_src;
      logic [31:0] ip_dst;
      logic [7:0]  ip_proto;
      logic [15:0] tp_src;
      logic [15:0] tp_dst;
      logic [15:0] prio;
   } entry_type;

   // controller to datapath
   typedef struct packed {
      logic load;       // capture request
      logic rd;         // read entry at scan address
      logic wr_append;  // write request entry at count
      logic wr_move;    // write last read entry at request slot
      logic rd_last;    // read entry at count-1
      logic scan_clr;   // restart scan
      logic eval;       // evaluate entry read last cycle
      logic cnt_inc;
      logic cnt_dec;
      logic cnt_clr;
      logic rsp_load;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic [1:0] cmd;
      logic       full;
      logic       bad_slot;
      logic       scan_done;
   } stat_type;

   function automatic logic prefix_ok(input logic [5:0] wild, input logic is_ip,
                                      input logic [31:0] pkt, input logic [31:0] ent);
      logic [31:0] m;
      m = (wild >= 6'd32) ? 32'd0 : (32'hFFFF_FFFF << wild[4:0]);
      return (wild >= 6'd32) || (ent == 32'd0) || (is_ip && ((pkt & m) == (ent & m)));
   endfunction

   function automatic logic entry_match(input entry_type e, input entry_type p);
      logic is_ip, ok, icmp, tcpudp;
      logic [31:0] wc;
      wc = e.wildcards;
      is_ip = p.ethertype == ETH_IPV4;
      icmp = is_ip && p.ip_proto == PROTO_ICMP;
      tcpudp = is_ip && (p.ip_proto == PROTO_TCP || p.ip_proto == PROTO_UDP);
      ok = (wc[WC_PORT] || p.in_port == e.in_port || e.in_port == '0)
         && (wc[WC_DLSRC] || p.eth_src == e.eth_src || e.eth_src == '0)
         && (wc[WC_DLDST] || p.eth_dst == e.eth_dst || e.eth_dst == '0)
         && (wc[WC_DLTYPE] || p.ethertype == e.ethertype || e.ethertype == '0)
         && (wc[WC_PROTO] || !is_ip || p.ip_proto == e.ip_proto || e.ip_proto == '0);
      if (p.ethertype != ETH_ARP) begin
         ok = ok && prefix_ok(wc[13:8], is_ip, p.ip_src, e.ip_src)
                 && prefix_ok(wc[19:14], is_ip, p.ip_dst, e.ip_dst);
         if (tcpudp)
            ok = ok && (wc[WC_TPSRC] || p.tp_src == e.tp_src || e.tp_src == '0)
                    && (wc[WC_TPDST] || p.tp_dst == e.tp_dst || e.tp_dst == '0);
         else if (icmp)
            ok = ok && (wc[WC_TPSRC] || {8'd0, p.tp_src[7:0]} == e.tp_src
                        || e.tp_src == '0)
                    && (wc[WC_TPDST] || {8'd0, p.tp_dst[7:0]} == e.tp_dst
                        || e.tp_dst == '0);
      end
      return ok;
   endfunction

endpackage

FILE: sv/oftl_ctrl.sv
// ----------------------------------------------------------------------------
// oftl_ctrl
// command sequencer for the flow table core
// ----------------------------------------------------------------------------
module oftl_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_stall,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   input  oftl_pkg::stat_type stat,
   output oftl_pkg::cmd_type  cmd
);
   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_DISP = 3'd1;
   localparam logic [2:0] S_SCAN = 3'd2;
   localparam logic [2:0] S_MOVE = 3'd3;
   localparam logic [2:0] S_RSP  = 3'd4;

   logic [2:0] state_ff, state_in;
   logic       rsp_valid_ff, rsp_valid_in;

   assign req_stall = (state_ff != S_IDLE) || rsp_valid_ff;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in = state_ff;
      rsp_valid_in = rsp_valid_ff && rsp_stall;
      cmd = '0;
      case (state_ff)
         S_IDLE: begin
            if (req_valid && !req_stall) begin
               cmd.load = 1'b1;
               state_in = S_DISP;
            end
         end
         S_DISP: begin
            case (stat.cmd)
               oftl_pkg::CMD_LOOKUP: begin
                  cmd.scan_clr = 1'b1;
                  state_in = S_SCAN;
               end
               oftl_pkg::CMD_APPEND: begin
                  if (!stat.full) begin
                     cmd.wr_append = 1'b1;
                     cmd.cnt_inc = 1'b1;
                  end
                  state_in = S_RSP;
               end
               oftl_pkg::CMD_REMOVE: begin
                  if (stat.bad_slot) state_in = S_RSP;
                  else begin
                     cmd.rd_last = 1'b1;
                     state_in = S_MOVE;
                  end
               end
               default: begin
                  cmd.cnt_clr = 1'b1;
                  state_in = S_RSP;
               end
            endcase
         end
         S_SCAN: begin
            // read of one slot overlaps evaluation of the previous one
            cmd.rd = 1'b1;
            cmd.eval = 1'b1;
            if (stat.scan_done) state_in = S_RSP;
         end
         S_MOVE: begin
            cmd.wr_move = 1'b1;
            cmd.cnt_dec = 1'b1;
            state_in = S_RSP;
         end
         S_RSP: begin
            cmd.rsp_load = 1'b1;
            rsp_valid_in = 1'b1;
            state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end
endmodule

FILE: sv/oftl_dpath.sv
// ----------------------------------------------------------------------------
// oftl_dpath
// entry memory, scan pointer, match compare and result registers
// ----------------------------------------------------------------------------
module oftl_dpath #(
   parameter int TABLE_DEPTH = oftl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic               clock,
   input  logic               reset,
   input  oftl_pkg::cmd_type  cmd,
   output oftl_pkg::stat_type stat,
   input  logic [1:0]         req_cmd,
   input  oftl_pkg::entry_type req_entry,
   output logic               rsp_matched,
   output logic [5:0]         rsp_flow_index,
   output logic [1:0]         rsp_status,
   output logic [6:0]         rsp_entry_count
);
   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CW = $clog2(TABLE_DEPTH + 1);
   localparam int IW = (AW < 6) ? AW : 6;

   oftl_pkg::entry_type mem [TABLE_DEPTH];
   oftl_pkg::entry_type rd_data_ff;
   oftl_pkg::entry_type req_ff;
   logic [1:0]    cmd_ff;
   logic [CW-1:0] count_ff, count_in;
   logic [CW-1:0] scan_ff;           // next slot to read
   logic [CW-1:0] eval_slot_ff;      // slot held in rd_data_ff
   logic          eval_vld_ff;
   logic          hit_ff;
   logic [AW-1:0] best_ff;
   logic [15:0]   best_pri_ff;
   logic [AW-1:0] rd_addr;
   logic          do_rd;
   logic          slot_ok;
   logic          m;
   logic          req_full_ff, rm_bad_ff;
   logic [AW-1:0] app_idx_ff;
   logic          rsp_matched_ff, rsp_matched_in;
   logic [5:0]    rsp_flow_index_ff, rsp_flow_index_in;
   logic [1:0]    rsp_status_ff, rsp_status_in;
   logic [6:0]    rsp_entry_count_ff;

   assign slot_ok = {16'd0, req_ff.prio} < {{(16 + 16 - CW){1'b0}}, count_ff};
   assign stat.cmd = cmd_ff;
   assign stat.full = count_ff >= CW'(TABLE_DEPTH);
   assign stat.bad_slot = !slot_ok;
   assign stat.scan_done = (scan_ff >= count_ff) && !eval_vld_ff;

   assign do_rd = (cmd.rd && scan_ff < count_ff) || cmd.rd_last;
   assign rd_addr = cmd.rd_last ? AW'(count_ff - CW'(1)) : AW'(scan_ff);

   always_ff @(posedge clock) begin
      if (cmd.wr_append) mem[AW'(count_ff)] <= req_ff;
      if (cmd.wr_move) mem[AW'(req_ff.prio)] <= rd_data_ff;
      if (do_rd) rd_data_ff <= mem[rd_addr];
      if (cmd.load) begin
         req_ff <= req_entry;
         cmd_ff <= req_cmd;
      end
   end

   assign m = eval_vld_ff && (!hit_ff || rd_data_ff.prio > best_pri_ff)
              && oftl_pkg::entry_match(rd_data_ff, req_ff);

   always_comb begin
      count_in = count_ff;
      if (cmd.cnt_clr) count_in = '0;
      else if (cmd.cnt_inc) count_in = count_ff + CW'(1);
      else if (cmd.cnt_dec) count_in = count_ff - CW'(1);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff <= '0;
         scan_ff <= '0;
         eval_vld_ff <= 1'b0;
         hit_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.scan_clr) begin
            scan_ff <= '0;
            eval_vld_ff <= 1'b0;
            hit_ff <= 1'b0;
         end else if (cmd.eval) begin
            eval_vld_ff <= cmd.rd && scan_ff < count_ff;
            if (cmd.rd && scan_ff < count_ff) scan_ff <= scan_ff + CW'(1);
            if (m) hit_ff <= 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.rd) eval_slot_ff <= scan_ff;
      if (m) begin
         best_ff <= AW'(eval_slot_ff);
         best_pri_ff <= rd_data_ff.prio;
      end
   end

   always_comb begin
      rsp_matched_in = 1'b0;
      rsp_flow_index_in = '0;
      rsp_status_in = oftl_pkg::ST_OK;
      case (cmd_ff)
         oftl_pkg::CMD_LOOKUP: begin
            rsp_matched_in = hit_ff;
            if (hit_ff) rsp_flow_index_in = 6'(best_ff[IW-1:0]);
         end
         oftl_pkg::CMD_APPEND: begin
            if (req_full_ff) rsp_status_in = oftl_pkg::ST_FULL;
            else rsp_flow_index_in = 6'(app_idx_ff[IW-1:0]);
         end
         oftl_pkg::CMD_REMOVE: begin
            if (rm_bad_ff) rsp_status_in = oftl_pkg::ST_SLOT;
            else rsp_flow_index_in = req_ff.prio[5:0];
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.rsp_load) begin
         rsp_entry_count_ff <= 7'(count_ff);
         rsp_matched_ff <= rsp_matched_in;
         rsp_flow_index_ff <= rsp_flow_index_in;
         rsp_status_ff <= rsp_status_in;
      end
   end

   assign rsp_matched = rsp_matched_ff;
   assign rsp_flow_index = rsp_flow_index_ff;
   assign rsp_status = rsp_status_ff;
   assign rsp_entry_count = rsp_entry_count_ff;

   // outcome of append and remove, captured at dispatch
   always_ff @(posedge clock) begin
      if (cmd.wr_append || (cmd_ff == oftl_pkg::CMD_APPEND && !cmd.rsp_load)) begin
         if (!cmd.rsp_load) begin
            req_full_ff <= stat.full;
            app_idx_ff <= AW'(count_ff);
         end
      end
      if (cmd.rd_last || (cmd_ff == oftl_pkg::CMD_REMOVE && !cmd.rsp_load && !cmd.wr_move))
         rm_bad_ff <= !slot_ok;
   end
endmodule

FILE: sv/openflow10_flow_table_lookup_core.sv
// ----------------------------------------------------------------------------
// openflow10_flow_table_lookup_core
// openflow 1.0 wildcard flow table with sequential priority lookup
// ----------------------------------------------------------------------------
// One item is taken at a time. A lookup reads one table slot per cycle from a
// single-port entry memory and compares it in the next, so its result follows
// the scan over all stored entries; append, clear and a rejected remove go from
// dispatch straight to the response state, a remove that moves an entry passes
// through a move state first. The next item is taken the cycle after the result
// leaves, so a stalled result holds off the input. The scan over the memory
// read port sets the lookup time. Highest priority wins, the lowest slot on
// a tie. Removing a slot moves the last entry into it.
module openflow10_flow_table_lookup_core #(
   parameter int TABLE_DEPTH = oftl_pkg::DEFAULT_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  logic [1:0]  req_cmd,
   input  logic [15:0] req_in_port,
   input  logic [47:0] req_eth_src,
   input  logic [47:0] req_eth_dst,
   input  logic [15:0] req_ethertype,
   input  logic [31:0] req_ip_src,
   input  logic [31:0] req_ip_dst,
   input  logic [7:0]  req_ip_proto,
   input  logic [15:0] req_tp_src,
   input  logic [15:0] req_tp_dst,
   input  logic [31:0] req_wildcards,
   input  logic [15:0] req_priority_or_slot,
   output logic        rsp_valid,
   input  logic        rsp_stall,
   output logic        rsp_matched,
   output logic [5:0]  rsp_flow_index,
   output logic [1:0]  rsp_status,
   output logic [6:0]  rsp_entry_count
);
   oftl_pkg::cmd_type   cmd;
   oftl_pkg::stat_type  stat;
   oftl_pkg::entry_type req_entry;

   // request fields packed as a table entry
   always_comb begin
      req_entry.wildcards = req_wildcards;
      req_entry.in_port = req_in_port;
      req_entry.eth_src = req_eth_src;
      req_entry.eth_dst = req_eth_dst;
      req_entry.ethertype = req_ethertype;
      req_entry.ip_src = req_ip_src;
      req_entry.ip_dst = req_ip_dst;
      req_entry.ip_proto = req_ip_proto;
      req_entry.tp_src = req_tp_src;
      req_entry.tp_dst = req_tp_dst;
      req_entry.prio = req_priority_or_slot;
   end

   oftl_ctrl u_ctrl (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall),
      .stat(stat), .cmd(cmd)
   );

   oftl_dpath #(.TABLE_DEPTH(TABLE_DEPTH)) u_dpath (
      .clock(clock), .reset(reset), .cmd(cmd), .stat(stat),
      .req_cmd(req_cmd), .req_entry(req_entry),
      .rsp_matched(rsp_matched), .rsp_flow_index(rsp_flow_index),
      .rsp_status(rsp_status), .rsp_entry_count(rsp_entry_count)
   );

   // a new item is never taken while a result waits
   a_no_accept_with_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> req_stall) else $error("item accepted while result pending");

   // an accepted item gives no result in the next cycle
   a_rsp_latency: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> !rsp_valid) else $error("result too early");

   // a lookup result never reports a hit with a bad status
   a_lookup_status: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_matched) |-> rsp_status == oftl_pkg::ST_OK)
      else $error("hit with error status");
endmodule
